>>> hdl/lwph_pkg.sv
// Shared types and constants for the LCD window/pixel host.
package lwph_pkg;

  // Request codes on the input channel
  typedef enum logic [2:0] {
    CMD_SET_WINDOW     = 3'd0,
    CMD_BEGIN_PLAIN    = 3'd1,
    CMD_BEGIN_CONTRARY = 3'd2,
    CMD_WRITE_PIXEL    = 3'd3,
    CMD_FILL_PIXEL     = 3'd4,
    CMD_BEGIN_READ     = 3'd5,
    CMD_READ_WORD      = 3'd6
  } cmd_t;

  // Result kinds on the output channel
  typedef enum logic [1:0] {
    KIND_CMD   = 2'd0,
    KIND_DATA  = 2'd1,
    KIND_PIXEL = 2'd2
  } kind_t;

  // Read-back word position
  typedef enum logic [1:0] {
    PH_DUMMY  = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2,
    PH_THIRD  = 2'd3
  } rd_phase_t;

  // Classified jobs handed from front to back
  typedef enum logic [2:0] {
    JOB_WINDOW     = 3'd0,
    JOB_MEM_WRITE  = 3'd1,
    JOB_DATA       = 3'd2,
    JOB_BEGIN_READ = 3'd3,
    JOB_READ       = 3'd4
  } job_op_t;

  typedef logic [3:0] step_t;

  typedef struct packed {
    job_op_t     op;
    logic        portrait;
    logic        pix_valid;
    logic        restore;
    logic [15:0] w0;   // column start, data word or read pixel
    logic [15:0] w1;   // column end
    logic [15:0] w2;   // page start
    logic [15:0] w3;   // page end
  } job_t;

  // Bus command codes
  localparam logic [15:0] DCS_MADCTL = 16'h0036;
  localparam logic [15:0] DCS_CASET  = 16'h002A;
  localparam logic [15:0] DCS_PASET  = 16'h002B;
  localparam logic [15:0] DCS_RAMWR  = 16'h002C;
  localparam logic [15:0] DCS_RAMRD  = 16'h002E;
  localparam logic [15:0] DCS_COLMOD = 16'h003A;

  // Command data words
  localparam logic [15:0] ACCESS_LANDSCAPE = 16'h00A0;
  localparam logic [15:0] ACCESS_PORTRAIT  = 16'h0000;
  localparam logic [15:0] COLMOD_18BIT     = 16'h0006;
  localparam logic [15:0] COLMOD_16BIT     = 16'h0005;

  // Pixel repacking masks
  localparam logic [15:0] MASK_RED   = 16'hF800;
  localparam logic [15:0] MASK_GREEN = 16'h00FC;
  localparam logic [15:0] MASK_LOW5  = 16'h00F8;
  localparam logic [15:0] MASK_HIGH6 = 16'hFC00;
  localparam logic [15:0] ALL_ONES   = 16'hFFFF;

  localparam logic [10:0] PANEL_WIDTH_RESET = 11'd320;

  // Result positions within a window request
  localparam step_t WIN_STEP_MADCTL = 4'd0;
  localparam step_t WIN_STEP_ACCESS = 4'd1;
  localparam step_t WIN_STEP_CASET  = 4'd2;
  localparam step_t WIN_STEP_XS_HI  = 4'd3;
  localparam step_t WIN_STEP_XS_LO  = 4'd4;
  localparam step_t WIN_STEP_XE_HI  = 4'd5;
  localparam step_t WIN_STEP_XE_LO  = 4'd6;
  localparam step_t WIN_STEP_PASET  = 4'd7;
  localparam step_t WIN_STEP_YS_HI  = 4'd8;
  localparam step_t WIN_STEP_YS_LO  = 4'd9;
  localparam step_t WIN_STEP_YE_HI  = 4'd10;

  // Result positions within begin-read and read-word requests
  localparam step_t SEQ_STEP_0 = 4'd0;
  localparam step_t SEQ_STEP_1 = 4'd1;

endpackage

>>> hdl/lwph_front.sv
// Front end: accepts requests, tracks write/read state and classifies into jobs.
module lwph_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [10:0]       cfg_wr_data,
  input  logic              in_valid,
  input  logic              in_ready,
  input  logic [2:0]        in_command,
  input  logic [9:0]        in_rect_x,
  input  logic [9:0]        in_rect_y,
  input  logic [10:0]       in_rect_width,
  input  logic [10:0]       in_rect_height,
  input  logic              in_portrait,
  input  logic [15:0]       in_pixel_value,
  input  logic              in_last_item,
  output logic              push_valid,
  output lwph_pkg::job_t    push_job
);

  logic [10:0]         panel_width_r;
  logic [15:0]         fill_colour_r, fill_colour_nxt;
  logic                contrary_mode_r, contrary_mode_nxt;
  lwph_pkg::rd_phase_t read_phase_r, read_phase_nxt;
  logic [15:0]         first_word_r, first_word_nxt;
  logic [15:0]         second_word_r, second_word_nxt;

  lwph_pkg::cmd_t cmd;
  logic           accept;
  logic           has_job;
  logic [15:0]    x16, y16, w16, h16, pw16;
  logic [15:0]    land_xe, land_ye, port_xe, port_ys, port_ye;
  logic [15:0]    pix_second, pix_third;

  assign cmd    = lwph_pkg::cmd_t'(in_command);
  assign accept = in_valid & in_ready;

  // Widen window fields to bus width
  assign x16  = {6'd0, in_rect_x};
  assign y16  = {6'd0, in_rect_y};
  assign w16  = {5'd0, in_rect_width};
  assign h16  = {5'd0, in_rect_height};
  assign pw16 = {5'd0, panel_width_r};

  // Window bounds, wrapping at 16 bits
  assign land_xe = x16 + w16 - 16'd1;
  assign land_ye = y16 + h16 - 16'd1;
  assign port_xe = y16 + h16 - 16'd1;
  assign port_ys = pw16 - (x16 + w16);
  assign port_ye = pw16 - x16 - 16'd1;

  // Repack three 18-bit-format bus words into two RGB565 pixels
  assign pix_second = (first_word_r & lwph_pkg::MASK_RED)
                    | ((first_word_r & lwph_pkg::MASK_GREEN) << 3)
                    | ((in_pixel_value & lwph_pkg::MASK_RED) >> 11);
  assign pix_third  = ((second_word_r & lwph_pkg::MASK_LOW5) << 8)
                    | ((in_pixel_value & lwph_pkg::MASK_HIGH6) >> 5)
                    | ((in_pixel_value & lwph_pkg::MASK_LOW5) >> 3);

  // Classify request and compute next state
  always_comb begin
    fill_colour_nxt   = fill_colour_r;
    contrary_mode_nxt = contrary_mode_r;
    read_phase_nxt    = read_phase_r;
    first_word_nxt    = first_word_r;
    second_word_nxt   = second_word_r;
    push_job          = '0;
    push_job.op       = lwph_pkg::JOB_DATA;
    has_job           = 1'b0;
    case (cmd)
      lwph_pkg::CMD_SET_WINDOW: begin
        has_job           = 1'b1;
        push_job.op       = lwph_pkg::JOB_WINDOW;
        push_job.portrait = in_portrait;
        if (in_portrait) begin
          push_job.w0 = y16;
          push_job.w1 = port_xe;
          push_job.w2 = port_ys;
          push_job.w3 = port_ye;
        end else begin
          push_job.w0 = x16;
          push_job.w1 = land_xe;
          push_job.w2 = y16;
          push_job.w3 = land_ye;
        end
      end
      lwph_pkg::CMD_BEGIN_PLAIN, lwph_pkg::CMD_BEGIN_CONTRARY: begin
        has_job           = 1'b1;
        push_job.op       = lwph_pkg::JOB_MEM_WRITE;
        fill_colour_nxt   = in_pixel_value;
        contrary_mode_nxt = (cmd == lwph_pkg::CMD_BEGIN_CONTRARY);
      end
      lwph_pkg::CMD_WRITE_PIXEL: begin
        has_job     = 1'b1;
        push_job.op = lwph_pkg::JOB_DATA;
        push_job.w0 = in_pixel_value;
      end
      lwph_pkg::CMD_FILL_PIXEL: begin
        has_job     = 1'b1;
        push_job.op = lwph_pkg::JOB_DATA;
        push_job.w0 = fill_colour_r;
        if (contrary_mode_r) begin
          fill_colour_nxt = fill_colour_r ^ lwph_pkg::ALL_ONES;
        end
      end
      lwph_pkg::CMD_BEGIN_READ: begin
        has_job        = 1'b1;
        push_job.op    = lwph_pkg::JOB_BEGIN_READ;
        read_phase_nxt = lwph_pkg::PH_DUMMY;
      end
      lwph_pkg::CMD_READ_WORD: begin
        push_job.op      = lwph_pkg::JOB_READ;
        push_job.restore = in_last_item;
        case (read_phase_r)
          lwph_pkg::PH_DUMMY: begin
            read_phase_nxt = lwph_pkg::PH_FIRST;
          end
          lwph_pkg::PH_FIRST: begin
            first_word_nxt = in_pixel_value;
            read_phase_nxt = lwph_pkg::PH_SECOND;
          end
          lwph_pkg::PH_SECOND: begin
            second_word_nxt    = in_pixel_value;
            push_job.pix_valid = 1'b1;
            push_job.w0        = pix_second;
            read_phase_nxt     = lwph_pkg::PH_THIRD;
          end
          default: begin
            push_job.pix_valid = 1'b1;
            push_job.w0        = pix_third;
            read_phase_nxt     = lwph_pkg::PH_FIRST;
          end
        endcase
        if (in_last_item) begin
          read_phase_nxt = lwph_pkg::PH_DUMMY;
        end
        has_job = push_job.pix_valid | in_last_item;
      end
      default: begin
        has_job = 1'b0;
      end
    endcase
  end

  assign push_valid = accept & has_job;

  // Hold configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      panel_width_r <= lwph_pkg::PANEL_WIDTH_RESET;
    end else if (cfg_wr_en) begin
      panel_width_r <= cfg_wr_data;
    end
  end

  // Advance request state on each accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_colour_r   <= '0;
      contrary_mode_r <= 1'b0;
      read_phase_r    <= lwph_pkg::PH_DUMMY;
      first_word_r    <= '0;
      second_word_r   <= '0;
    end else if (accept) begin
      fill_colour_r   <= fill_colour_nxt;
      contrary_mode_r <= contrary_mode_nxt;
      read_phase_r    <= read_phase_nxt;
      first_word_r    <= first_word_nxt;
      second_word_r   <= second_word_nxt;
    end
  end

endmodule

>>> hdl/lwph_fifo.sv
// Small register queue of classified jobs between front and back.
module lwph_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  lwph_pkg::job_t               push_job,
  input  logic                         pop,
  output logic                         head_valid,
  output lwph_pkg::job_t               head_job,
  output logic                         full,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH+1);

  lwph_pkg::job_t   slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign head_valid = (count_r != '0);
  assign head_job   = slots_r[rd_ptr_r];
  assign full       = (count_r == CNT_W'(DEPTH));
  assign count      = count_r;

  // Store pushed job
  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

>>> hdl/lwph_back.sv
// Back end: expands each job into bus results, one per cycle while out_ready allows, into an output register.
module lwph_back (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             head_valid,
  input  lwph_pkg::job_t   head_job,
  output logic             pop,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [1:0]       out_kind,
  output logic [15:0]      out_value,
  output logic             out_end_of_run
);

  lwph_pkg::step_t step_r;
  lwph_pkg::step_t eff_step;
  lwph_pkg::kind_t res_kind;
  logic [15:0]     res_value;
  logic            res_end;
  logic            load;

  logic            out_valid_r;
  lwph_pkg::kind_t out_kind_r;
  logic [15:0]     out_value_r;
  logic            out_end_r;

  // Skip the pixel slot of a read job that carries no pixel
  assign eff_step = step_r + lwph_pkg::step_t'((head_job.op == lwph_pkg::JOB_READ)
                                               && !head_job.pix_valid);

  // Select the result at the current step
  always_comb begin
    res_kind  = lwph_pkg::KIND_DATA;
    res_value = '0;
    res_end   = 1'b1;
    case (head_job.op)
      lwph_pkg::JOB_WINDOW: begin
        res_end = 1'b0;
        case (eff_step)
          lwph_pkg::WIN_STEP_MADCTL: begin
            res_kind  = lwph_pkg::KIND_CMD;
            res_value = lwph_pkg::DCS_MADCTL;
          end
          lwph_pkg::WIN_STEP_ACCESS: begin
            res_value = head_job.portrait ? lwph_pkg::ACCESS_PORTRAIT
                                          : lwph_pkg::ACCESS_LANDSCAPE;
          end
          lwph_pkg::WIN_STEP_CASET: begin
            res_kind  = lwph_pkg::KIND_CMD;
            res_value = lwph_pkg::DCS_CASET;
          end
          lwph_pkg::WIN_STEP_XS_HI: res_value = {8'd0, head_job.w0[15:8]};
          lwph_pkg::WIN_STEP_XS_LO: res_value = {8'd0, head_job.w0[7:0]};
          lwph_pkg::WIN_STEP_XE_HI: res_value = {8'd0, head_job.w1[15:8]};
          lwph_pkg::WIN_STEP_XE_LO: res_value = {8'd0, head_job.w1[7:0]};
          lwph_pkg::WIN_STEP_PASET: begin
            res_kind  = lwph_pkg::KIND_CMD;
            res_value = lwph_pkg::DCS_PASET;
          end
          lwph_pkg::WIN_STEP_YS_HI: res_value = {8'd0, head_job.w2[15:8]};
          lwph_pkg::WIN_STEP_YS_LO: res_value = {8'd0, head_job.w2[7:0]};
          lwph_pkg::WIN_STEP_YE_HI: res_value = {8'd0, head_job.w3[15:8]};
          default: begin
            res_value = {8'd0, head_job.w3[7:0]};
            res_end   = 1'b1;
          end
        endcase
      end
      lwph_pkg::JOB_MEM_WRITE: begin
        res_kind  = lwph_pkg::KIND_CMD;
        res_value = lwph_pkg::DCS_RAMWR;
      end
      lwph_pkg::JOB_DATA: begin
        res_value = head_job.w0;
      end
      lwph_pkg::JOB_BEGIN_READ: begin
        res_end = 1'b0;
        case (eff_step)
          lwph_pkg::SEQ_STEP_0: begin
            res_kind  = lwph_pkg::KIND_CMD;
            res_value = lwph_pkg::DCS_COLMOD;
          end
          lwph_pkg::SEQ_STEP_1: res_value = lwph_pkg::COLMOD_18BIT;
          default: begin
            res_kind  = lwph_pkg::KIND_CMD;
            res_value = lwph_pkg::DCS_RAMRD;
            res_end   = 1'b1;
          end
        endcase
      end
      default: begin
        // Read word: optional pixel, then optional format restore
        case (eff_step)
          lwph_pkg::SEQ_STEP_0: begin
            res_kind  = lwph_pkg::KIND_PIXEL;
            res_value = head_job.w0;
            res_end   = !head_job.restore;
          end
          lwph_pkg::SEQ_STEP_1: begin
            res_kind  = lwph_pkg::KIND_CMD;
            res_value = lwph_pkg::DCS_COLMOD;
            res_end   = 1'b0;
          end
          default: res_value = lwph_pkg::COLMOD_16BIT;
        endcase
      end
    endcase
  end

  assign load = head_valid && (!out_valid_r || out_ready);
  assign pop  = load && res_end;

  // Advance the step within the head job
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (load) begin
      step_r <= res_end ? '0 : step_r + 1'b1;
    end
  end

  // Hold output valid until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Load output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_kind_r  <= res_kind;
      out_value_r <= res_value;
      out_end_r   <= res_end;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_value      = out_value_r;
  assign out_end_of_run = out_end_r;

endmodule

>>> hdl/lcd_window_pixel_host.sv
// Top level of the LCD window/pixel host: front end, job queue and back end.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------------------
//  in_     | input     | in_valid / in_ready  | command, rect_x/y/width/height, portrait,
//          |           |                      | pixel_value, last_item
//  out_    | output    | out_valid/out_ready  | kind, value, end_of_run
//  cfg_    | input     | cfg_wr_en, no wait   | panel_width (11 bits)
//
// Requests that give one result or none are taken one per cycle; the back end's output
// register issues one result per cycle while out_ready allows, so set-window gives 12
// results, begin-read 3 and a last read word up to 3. The registered QUEUE_DEPTH-entry job
// queue absorbs those runs; in_ready drops only while the queue is full.
// Synchronous active-low reset clears control and request state; panel_width resets to 320.
module lcd_window_pixel_host #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [10:0] cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_command,
  input  logic [9:0]  in_rect_x,
  input  logic [9:0]  in_rect_y,
  input  logic [10:0] in_rect_width,
  input  logic [10:0] in_rect_height,
  input  logic        in_portrait,
  input  logic [15:0] in_pixel_value,
  input  logic        in_last_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [15:0] out_value,
  output logic        out_end_of_run
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH+1);

  logic             q_push, q_pop, q_full, q_head_valid;
  lwph_pkg::job_t   q_push_job, q_head_job;
  logic [CNT_W-1:0] q_count;

  assign in_ready = !q_full;

  // Classify requests
  lwph_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_rect_x      (in_rect_x),
    .in_rect_y      (in_rect_y),
    .in_rect_width  (in_rect_width),
    .in_rect_height (in_rect_height),
    .in_portrait    (in_portrait),
    .in_pixel_value (in_pixel_value),
    .in_last_item   (in_last_item),
    .push_valid     (q_push),
    .push_job       (q_push_job)
  );

  // Queue jobs
  lwph_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_job   (q_push_job),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_job   (q_head_job),
    .full       (q_full),
    .count      (q_count)
  );

  // Expand jobs into results
  lwph_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (q_head_valid),
    .head_job       (q_head_job),
    .pop            (q_pop),
    .out_ready      (out_ready),
    .out_valid      (out_valid),
    .out_kind       (out_kind),
    .out_value      (out_value),
    .out_end_of_run (out_end_of_run)
  );

`ifndef SYNTHESIS
  // Never push into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_full |-> !q_push)
    else $error("job pushed into full queue");

  // Occupancy stays within depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("queue occupancy beyond depth");

  // Retiring a job presents its closing result
  a_pop_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> (out_valid && out_end_of_run))
    else $error("job retired without end-of-run result");
`endif

endmodule
